[rtl/assert_macros.svh]
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/bsa_pkg.sv]
// Shared types and constants for the bitmap slot allocator.
`timescale 1ns / 1ps
package bsa_pkg;
  localparam int MaxSlots = 256;
  localparam int SlotW = 8;
  localparam int AddrW = 48;
  localparam int BsW = 16;
  localparam int CntW = 9;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_DOUBLE = 2'd3;

  localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [1:0] REG_SLOT_BYTES = 2'd1;
  localparam logic [1:0] REG_BASE = 2'd2;

  typedef struct packed {
    logic             is_free;
    logic             below_base;
    logic [AddrW-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot_index;
    logic [AddrW-1:0] block_address;
    logic             any_free;
    logic             all_free;
  } res_t;
endpackage

[rtl/bitmap_slot_allocator_top.sv]
// Top level of the bitmap slot allocator.
`timescale 1ns / 1ps
// Hands out fixed-size slots from a pool of up to 256 tracked in a free bitmap. A free runs
// a 48-step restoring divider by the slot size (a free below the base skips it), an alloc
// scans the bitmap 32 slots a cycle, and both then count free slots. Commands are handled
// one at a time.
// A two-entry queue sits between the command front end and the executing back end, and
// a result register lets new commands queue while the last result waits.
module bitmap_slot_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] cmd
  input  logic [47:0] in_tdata,   // [47:0] free_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [1:0] status, [9:2] slot_index, [57:10] block_address,
                                  // [58] any_free, [59] all_free, zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [bsa_pkg::CntW-1:0]  slot_count_r;
  logic [bsa_pkg::BsW-1:0]   slot_bytes_r;
  logic [bsa_pkg::AddrW-1:0] base_r;
  logic                      q_valid, q_ready;
  bsa_pkg::cmd_t             q_data;
  bsa_pkg::res_t             res;

  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[4:3])
      bsa_pkg::REG_SLOT_COUNT: cfg_prdata = 64'(slot_count_r);
      bsa_pkg::REG_SLOT_BYTES: cfg_prdata = 64'(slot_bytes_r);
      bsa_pkg::REG_BASE:       cfg_prdata = 64'(base_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= bsa_pkg::CntW'(256);
      slot_bytes_r <= bsa_pkg::BsW'(16);
      base_r       <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[4:3])
        bsa_pkg::REG_SLOT_COUNT: slot_count_r <= cfg_pwdata[bsa_pkg::CntW-1:0];
        bsa_pkg::REG_SLOT_BYTES: slot_bytes_r <= cfg_pwdata[bsa_pkg::BsW-1:0];
        bsa_pkg::REG_BASE:       base_r <= cfg_pwdata[bsa_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  bsa_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .cmd(in_tuser), .free_address(in_tdata),
    .base_address(base_r),
    .q_valid, .q_ready, .q_data
  );

  bsa_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .slot_count(slot_count_r), .slot_bytes(slot_bytes_r), .base_address(base_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  assign out_tdata = {4'd0, res.all_free, res.any_free, res.block_address,
                      res.slot_index, res.status};
endmodule

[rtl/bsa_front.sv]
// Front end: accept commands, compute offset from base, queue them.
`timescale 1ns / 1ps
module bsa_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [bsa_pkg::AddrW-1:0]  free_address,
  input  logic [bsa_pkg::AddrW-1:0]  base_address,
  output logic                       q_valid,
  input  logic                       q_ready,
  output bsa_pkg::cmd_t              q_data
);
  bsa_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  bsa_pkg::cmd_t c;
  logic          push, pop;

  always_comb begin
    c.is_free    = (cmd == bsa_pkg::CMD_FREE);
    c.below_base = free_address < base_address;
    c.offset     = free_address - base_address;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_cnt_max, cnt_r <= 2'd2, "queue count overflow")
  `ASSERT_CLK(a_no_pop_empty, (cnt_r == 2'd0) |-> !pop, "pop from empty queue")
  `ASSERT_CLK(a_cnt_step, (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1),
              "count did not advance")
endmodule

[rtl/bsa_back.sv]
// Back end: divider, bitmap scan and update, result register.
`timescale 1ns / 1ps
module bsa_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  bsa_pkg::cmd_t                q_data,
  input  logic [bsa_pkg::CntW-1:0]     slot_count,
  input  logic [bsa_pkg::BsW-1:0]      slot_bytes,
  input  logic [bsa_pkg::AddrW-1:0]    base_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bsa_pkg::res_t                out_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam int ChunkN = 32;
  localparam int Chunks = bsa_pkg::MaxSlots / ChunkN;

  logic [2:0]                  st_r;
  logic [bsa_pkg::MaxSlots-1:0] map_r;
  logic [bsa_pkg::AddrW-1:0]   rem_r, quo_r;
  logic [5:0]                  dcnt_r;
  logic [2:0]                  ch_r;
  logic [1:0]                  status_r;
  logic [bsa_pkg::SlotW-1:0]   idx_r;
  logic [bsa_pkg::AddrW-1:0]   addr_r;
  logic                        any_r, all_r, is_free_r;
  logic                        ovalid_r;
  bsa_pkg::res_t               res_r;

  logic [bsa_pkg::CntW-1:0]    n;
  logic [bsa_pkg::BsW-1:0]     bs;
  logic [bsa_pkg::MaxSlots-1:0] act;
  logic [ChunkN-1:0]           chunk, achunk;
  logic [4:0]                  low;
  logic                        hit;
  logic [bsa_pkg::AddrW:0]     trial;
  logic [bsa_pkg::AddrW-1:0]   rsh;
  logic [bsa_pkg::CntW-1:0]    slot_ext;
  logic [23:0]                 prod;

  always_comb begin
    n = (slot_count == '0) ? bsa_pkg::CntW'(1) :
        (slot_count > bsa_pkg::CntW'(bsa_pkg::MaxSlots)) ?
        bsa_pkg::CntW'(bsa_pkg::MaxSlots) : slot_count;
    bs = (slot_bytes == '0) ? bsa_pkg::BsW'(1) : slot_bytes;
    for (int i = 0; i < bsa_pkg::MaxSlots; i++) begin
      act[i] = (bsa_pkg::CntW'(i) < n);
    end
    chunk  = map_r[ch_r*ChunkN +: ChunkN] & act[ch_r*ChunkN +: ChunkN];
    achunk = act[ch_r*ChunkN +: ChunkN];
    hit = |chunk;
    low = '0;
    for (int i = ChunkN-1; i >= 0; i--) begin
      if (chunk[i]) low = 5'(i);
    end
    rsh   = {rem_r[bsa_pkg::AddrW-2:0], quo_r[bsa_pkg::AddrW-1]};
    trial = {1'b0, rsh} - {{(bsa_pkg::AddrW-bsa_pkg::BsW+1){1'b0}}, bs};
    slot_ext = bsa_pkg::CntW'(quo_r[bsa_pkg::SlotW-1:0]);
    prod = {16'd0, idx_r} * {8'd0, bs};
  end

  assign q_ready   = (st_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      map_r    <= '1;
      ovalid_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            is_free_r <= q_data.is_free;
            rem_r     <= '0;
            quo_r     <= q_data.offset;
            dcnt_r    <= '0;
            ch_r      <= '0;
            idx_r     <= '0;
            addr_r    <= '0;
            any_r     <= 1'b0;
            all_r     <= 1'b1;
            status_r  <= bsa_pkg::ST_OK;
            if (q_data.is_free) begin
              if (q_data.below_base) begin
                status_r <= bsa_pkg::ST_RANGE;
                st_r     <= S_CNT;
              end else begin
                st_r <= S_DIV;
              end
            end else begin
              st_r <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          quo_r <= {quo_r[bsa_pkg::AddrW-2:0], ~trial[bsa_pkg::AddrW]};
          rem_r <= trial[bsa_pkg::AddrW] ? rsh : trial[bsa_pkg::AddrW-1:0];
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'(bsa_pkg::AddrW-1)) st_r <= S_MUL;
        end
        S_SCAN: begin
          if (hit) begin
            idx_r   <= {ch_r, low};
            map_r[{ch_r, low}] <= 1'b0;
            st_r <= S_MUL;
          end else if (ch_r == 3'(Chunks-1)) begin
            status_r <= bsa_pkg::ST_FULL;
            ch_r <= '0;
            st_r <= S_CNT;
          end else begin
            ch_r <= ch_r + 3'd1;
          end
        end
        S_MUL: begin
          if (is_free_r) begin
            if ((quo_r[bsa_pkg::AddrW-1:bsa_pkg::SlotW] != '0) || (slot_ext >= n)) begin
              status_r <= bsa_pkg::ST_RANGE;
            end else if (map_r[quo_r[bsa_pkg::SlotW-1:0]]) begin
              status_r <= bsa_pkg::ST_DOUBLE;
              idx_r    <= quo_r[bsa_pkg::SlotW-1:0];
            end else begin
              map_r[quo_r[bsa_pkg::SlotW-1:0]] <= 1'b1;
              idx_r <= quo_r[bsa_pkg::SlotW-1:0];
            end
          end else begin
            addr_r <= base_address + bsa_pkg::AddrW'(prod);
          end
          st_r <= S_CNT;
          ch_r <= '0;
          any_r <= 1'b0;
          all_r <= 1'b1;
        end
        S_CNT: begin
          if (|chunk) any_r <= 1'b1;
          if ((chunk ^ achunk) != '0) all_r <= 1'b0;
          if (ch_r == 3'(Chunks-1)) st_r <= S_OUT;
          ch_r <= ch_r + 3'd1;
        end
        S_OUT: begin
          if (!ovalid_r || out_ready) begin
            res_r.status        <= status_r;
            res_r.slot_index    <= idx_r;
            res_r.block_address <= addr_r;
            res_r.any_free      <= any_r;
            res_r.all_free      <= all_r;
            ovalid_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      if (ovalid_r && out_ready && !(st_r == S_OUT)) ovalid_r <= 1'b0;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_ok_alloc_used, (st_r == S_OUT && !is_free_r && status_r == bsa_pkg::ST_OK)
              |-> !map_r[idx_r], "allocated slot still free")
  `ASSERT_CLK(a_ok_free_set, (st_r == S_OUT && is_free_r && status_r == bsa_pkg::ST_OK)
              |-> map_r[idx_r], "freed slot not marked")
  `ASSERT_CLK(a_div_len, (st_r == S_DIV) |-> (dcnt_r < 6'(bsa_pkg::AddrW)),
              "divider overrun")
endmodule
